### hdl/bifs_pkg.sv
package bifs_pkg;

  localparam int unsigned DEPTH_BITS = 8;
  localparam int unsigned LEN_BITS   = 32;
  localparam int unsigned ACC_BITS   = LEN_BITS + 4;

  localparam logic [7:0] CH_I     = 8'h69;  // 'i'
  localparam logic [7:0] CH_N     = 8'h6e;  // 'n'
  localparam logic [7:0] CH_F     = 8'h66;  // 'f'
  localparam logic [7:0] CH_O     = 8'h6f;  // 'o'
  localparam logic [7:0] CH_D     = 8'h64;  // 'd'
  localparam logic [7:0] CH_L     = 8'h6c;  // 'l'
  localparam logic [7:0] CH_E     = 8'h65;  // 'e'
  localparam logic [7:0] CH_COLON = 8'h3a;  // ':'
  localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'
  localparam logic [7:0] CH_DOT   = 8'h2e;  // '.'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  localparam logic [2:0] MATCH_LAST = 3'd4;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_INFO   = 2'd1,
    PH_DONE   = 2'd2,
    PH_ERROR  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    TM_START = 2'd0,
    TM_INT   = 2'd1,
    TM_LEN   = 2'd2,
    TM_SKIP  = 2'd3
  } tmode_t;

  typedef enum logic [1:0] {
    ST_OUT   = 2'd0,
    ST_IN    = 2'd1,
    ST_CLOSE = 2'd2,
    ST_ERR   = 2'd3
  } status_t;

  typedef struct packed {
    logic       step;
    logic [7:0] data_byte;
    logic       final_byte;
  } scan_req_t;

  // Pattern "infod", one byte per match position
  function automatic logic [7:0] pat_byte(input logic [2:0] pos);
    logic [7:0] b;
    unique case (pos)
      3'd0:    b = CH_I;
      3'd1:    b = CH_N;
      3'd2:    b = CH_F;
      3'd3:    b = CH_O;
      default: b = CH_D;
    endcase
    return b;
  endfunction

endpackage

### hdl/bifs_in_if.sv
interface bifs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

### hdl/bifs_out_if.sv
interface bifs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [1:0] span_status;

  modport source (output valid, output byte_out, output span_status, input ready);
  modport sink   (input valid, input byte_out, input span_status, output ready);
endinterface

### hdl/bencode_info_span_finder.sv
// Info-dictionary span finder for a bencoded metainfo stream.
// in_ch carries one buffer byte per transfer, with final_byte set on the last
// byte of each buffer. out_ch returns exactly one transfer per input byte: the
// byte unchanged plus a span status (0 outside info, 1 inside info, 2 closing
// byte of info, 3 error or pattern not found), ready for a downstream hasher.
// Both channels use valid/ready; a transfer happens when both are high.
// A byte taken from in_ch waits in the input register, then passes through the
// scan logic into the output register, from which out_ch offers its transfer.
// Throughput: one byte per cycle while out_ch does not stall, set by the
// scanner's state update (pattern match, nesting depth, length accumulate
// by ten).
// When out_ch stalls the output register holds its transfer and the input
// register keeps taking one more byte; in_ch.ready drops only while both are
// full and out_ch.ready is low.
// Reset (synchronous, active low) empties both registers and returns the
// scanner to pattern search. The scanner also returns to that state after
// every byte marked final_byte, so each buffer is scanned on its own.
module bencode_info_span_finder (
  input logic            clk,
  input logic            rst_n,
  bifs_in_if.sink        in_ch,
  bifs_out_if.source     out_ch
);

  logic                 s1_valid_r, s1_valid_nxt;
  logic [7:0]           s1_byte_r;
  logic                 s1_final_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r;
  bifs_pkg::status_t    out_status_r;
  logic                 in_xfer;
  logic                 adv;
  bifs_pkg::scan_req_t  req;
  bifs_pkg::status_t    status;

  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_xfer || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_ch.ready);

  assign req.step       = adv;
  assign req.data_byte  = s1_byte_r;
  assign req.final_byte = s1_final_r;

  bifs_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r  <= in_ch.data_byte;
      s1_final_r <= in_ch.final_byte;
    end
    if (adv) begin
      out_byte_r   <= s1_byte_r;
      out_status_r <= status;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.byte_out    = out_byte_r;
  assign out_ch.span_status = out_status_r;

`ifndef SYNTHESIS
  // a byte waiting in the input register is neither lost nor altered
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input register lost or changed a waiting byte");

  // the byte after a final byte starts a new search: never inside or closing
  a_new_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_final_r |=> !adv || status == bifs_pkg::ST_OUT || status == bifs_pkg::ST_ERR)
    else $error("scanner not back in search after end of buffer");

  // every scanned byte lands in the output register unchanged
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r && out_byte_r == $past(s1_byte_r))
    else $error("byte not passed through to the output register");
`endif

endmodule

### hdl/bifs_scan.sv
module bifs_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  bifs_pkg::scan_req_t req,
  output bifs_pkg::status_t   status
);

  bifs_pkg::phase_t                   phase_r, phase_nxt;
  logic [2:0]                         match_r, match_nxt;
  bifs_pkg::tmode_t                   tmode_r, tmode_nxt;
  logic [bifs_pkg::DEPTH_BITS-1:0]    depth_r, depth_nxt;
  logic [bifs_pkg::LEN_BITS-1:0]      acc_r, acc_nxt;
  logic                               frac_r, frac_nxt;
  logic [bifs_pkg::LEN_BITS-1:0]      skip_r, skip_nxt;

  logic [7:0]                         c;
  logic                               is_digit;
  logic [3:0]                         dval;
  logic [bifs_pkg::ACC_BITS-1:0]      acc_x10;
  logic                               acc_ovf;
  logic [2:0]                         pos;

  assign c        = req.data_byte;
  assign is_digit = (c >= bifs_pkg::CH_ZERO) && (c <= bifs_pkg::CH_NINE);
  assign dval     = c[3:0];
  // acc*10 + d; a carry into the top four bits means the length no longer fits
  assign acc_x10  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                  + {{(bifs_pkg::ACC_BITS-4){1'b0}}, dval};
  assign acc_ovf  = |acc_x10[bifs_pkg::ACC_BITS-1:bifs_pkg::LEN_BITS];
  assign pos      = (match_r > bifs_pkg::MATCH_LAST) ? 3'd0 : match_r;

  always_comb begin
    phase_nxt = phase_r;
    match_nxt = match_r;
    tmode_nxt = tmode_r;
    depth_nxt = depth_r;
    acc_nxt   = acc_r;
    frac_nxt  = frac_r;
    skip_nxt  = skip_r;
    status    = bifs_pkg::ST_OUT;

    unique case (phase_r)
      bifs_pkg::PH_SEARCH: begin
        if (c == bifs_pkg::pat_byte(pos)) begin
          if (pos == bifs_pkg::MATCH_LAST) begin
            phase_nxt = bifs_pkg::PH_INFO;
            match_nxt = 3'd0;
            tmode_nxt = bifs_pkg::TM_START;
            depth_nxt = {{(bifs_pkg::DEPTH_BITS-1){1'b0}}, 1'b1};
            status    = bifs_pkg::ST_IN;
          end else begin
            match_nxt = pos + 3'd1;
          end
        end else begin
          match_nxt = (c == bifs_pkg::CH_I) ? 3'd1 : 3'd0;
        end
      end

      bifs_pkg::PH_INFO: begin
        status = bifs_pkg::ST_IN;
        unique case (tmode_r)
          bifs_pkg::TM_INT: begin
            if (c == bifs_pkg::CH_E) tmode_nxt = bifs_pkg::TM_START;
          end
          bifs_pkg::TM_SKIP: begin
            skip_nxt = skip_r - 1'b1;
            if (skip_r == {{(bifs_pkg::LEN_BITS-1){1'b0}}, 1'b1}) begin
              tmode_nxt = bifs_pkg::TM_START;
            end
          end
          bifs_pkg::TM_LEN: begin
            priority if (c == bifs_pkg::CH_COLON) begin
              skip_nxt  = acc_r;
              tmode_nxt = (acc_r == '0) ? bifs_pkg::TM_START : bifs_pkg::TM_SKIP;
            end else if (frac_r) begin
              // drop fractional digits and any other byte until the colon
            end else if (is_digit) begin
              if (acc_ovf) begin
                phase_nxt = bifs_pkg::PH_ERROR;
                status    = bifs_pkg::ST_ERR;
              end else begin
                acc_nxt = acc_x10[bifs_pkg::LEN_BITS-1:0];
              end
            end else if (c == bifs_pkg::CH_DOT) begin
              frac_nxt = 1'b1;
            end else begin
              phase_nxt = bifs_pkg::PH_ERROR;
              status    = bifs_pkg::ST_ERR;
            end
          end
          default: begin
            priority if (c == bifs_pkg::CH_I) begin
              tmode_nxt = bifs_pkg::TM_INT;
            end else if (c == bifs_pkg::CH_L || c == bifs_pkg::CH_D) begin
              if (depth_r == '1) begin
                phase_nxt = bifs_pkg::PH_ERROR;
                status    = bifs_pkg::ST_ERR;
              end else begin
                depth_nxt = depth_r + 1'b1;
              end
            end else if (c == bifs_pkg::CH_E) begin
              depth_nxt = depth_r - 1'b1;
              if (depth_r == {{(bifs_pkg::DEPTH_BITS-1){1'b0}}, 1'b1}) begin
                phase_nxt = bifs_pkg::PH_DONE;
                status    = bifs_pkg::ST_CLOSE;
              end
            end else begin
              acc_nxt  = '0;
              frac_nxt = 1'b0;
              priority if (c == bifs_pkg::CH_COLON) begin
                skip_nxt  = '0;
                tmode_nxt = bifs_pkg::TM_START;
              end else if (is_digit) begin
                tmode_nxt = bifs_pkg::TM_LEN;
                acc_nxt   = {{(bifs_pkg::LEN_BITS-4){1'b0}}, dval};
              end else if (c == bifs_pkg::CH_PLUS) begin
                tmode_nxt = bifs_pkg::TM_LEN;
              end else if (c == bifs_pkg::CH_DOT) begin
                tmode_nxt = bifs_pkg::TM_LEN;
                frac_nxt  = 1'b1;
              end else begin
                phase_nxt = bifs_pkg::PH_ERROR;
                status    = bifs_pkg::ST_ERR;
              end
            end
          end
        endcase
      end

      bifs_pkg::PH_ERROR: status = bifs_pkg::ST_ERR;

      default: status = bifs_pkg::ST_OUT;
    endcase

    // end of buffer: flag an unfinished span or a pattern not found, then start afresh
    if (req.final_byte) begin
      if (phase_nxt == bifs_pkg::PH_SEARCH || phase_nxt == bifs_pkg::PH_INFO) begin
        status = bifs_pkg::ST_ERR;
      end
      phase_nxt = bifs_pkg::PH_SEARCH;
      match_nxt = 3'd0;
      tmode_nxt = bifs_pkg::TM_START;
      depth_nxt = '0;
      acc_nxt   = '0;
      frac_nxt  = 1'b0;
      skip_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bifs_pkg::PH_SEARCH;
      match_r <= 3'd0;
      tmode_r <= bifs_pkg::TM_START;
      depth_r <= '0;
      acc_r   <= '0;
      frac_r  <= 1'b0;
      skip_r  <= '0;
    end else if (req.step) begin
      phase_r <= phase_nxt;
      match_r <= match_nxt;
      tmode_r <= tmode_nxt;
      depth_r <= depth_nxt;
      acc_r   <= acc_nxt;
      frac_r  <= frac_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule
